/* sv/string_literal_escaper_assert.svh */
// assertion macros used by the checker of the escaper
`ifndef STRING_LITERAL_ESCAPER_ASSERT_SVH
`define STRING_LITERAL_ESCAPER_ASSERT_SVH

// property that must hold on every edge outside reset
`define SLE_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("escaper check failed");

// antecedent in a cycle implies consequent in the next
`define SLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escaper check failed");

`endif

/* sv/sle_pkg.sv */
package sle_pkg;

   localparam int unsigned SeqDepth = 6;

   localparam logic [7:0] CHAR_QUOTE     = 8'd34;
   localparam logic [7:0] CHAR_APOSTR    = 8'd39;
   localparam logic [7:0] CHAR_BACKSLASH = 8'd92;
   localparam logic [7:0] CHAR_X         = 8'd120;
   localparam logic [7:0] LOW_PRINTABLE  = 8'd32;
   localparam logic [7:0] HIGH_PRINTABLE = 8'd126;

   // expanded characters of one input beat, entry 0 goes out first
   typedef struct packed {
      logic [SeqDepth-1:0][7:0] seq;
      logic [2:0]               count;
   } sle_expand_type;

   // letter after the backslash for a two-character escape, zero if none
   function automatic logic [7:0] short_letter(input logic [7:0] b);
      logic [7:0] r;
      begin
         unique case (b)
            8'd7:           r = 8'd97;
            8'd8:           r = 8'd98;
            8'd27:          r = 8'd101;
            8'd12:          r = 8'd102;
            8'd10:          r = 8'd110;
            8'd13:          r = 8'd114;
            8'd9:           r = 8'd116;
            8'd11:          r = 8'd118;
            CHAR_BACKSLASH: r = CHAR_BACKSLASH;
            CHAR_APOSTR:    r = CHAR_APOSTR;
            CHAR_QUOTE:     r = CHAR_QUOTE;
            default:        r = 8'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return {4'h0, v} + ((v < 4'd10) ? 8'd48 : 8'd87);
   endfunction

endpackage

/* sv/sle_expand.sv */
module sle_expand (
   input  logic [7:0]              ch,
   input  logic                    is_first,
   input  logic                    is_last,
   input  logic                    no_char,
   output sle_pkg::sle_expand_type expand
);

   logic [3:0][7:0] body;
   logic [2:0]      body_len;
   logic [2:0]      offset;
   logic [7:0]      letter;

   always_comb begin
      letter   = sle_pkg::short_letter(ch);
      body     = '0;
      body_len = 3'd0;
      if (!no_char) begin
         if (letter != 8'd0) begin
            body[0]  = sle_pkg::CHAR_BACKSLASH;
            body[1]  = letter;
            body_len = 3'd2;
         end else if (ch < sle_pkg::LOW_PRINTABLE || ch > sle_pkg::HIGH_PRINTABLE) begin
            body[0]  = sle_pkg::CHAR_BACKSLASH;
            body[1]  = sle_pkg::CHAR_X;
            body[2]  = sle_pkg::hex_digit(ch[7:4]);
            body[3]  = sle_pkg::hex_digit(ch[3:0]);
            body_len = 3'd4;
         end else begin
            body[0]  = ch;
            body_len = 3'd1;
         end
      end

      offset     = {2'b00, is_first};
      expand.seq = '0;
      if (is_first) begin
         expand.seq[0] = sle_pkg::CHAR_QUOTE;
      end
      for (int j = 0; j < 4; j++) begin
         if (3'(j) < body_len) begin
            expand.seq[3'(j) + offset] = body[j];
         end
      end
      if (is_last) begin
         expand.seq[offset + body_len] = sle_pkg::CHAR_QUOTE;
      end
      expand.count = offset + body_len + {2'b00, is_last};
   end

endmodule

/* sv/string_literal_escaper.sv */
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_ch, req_is_first, req_is_last, req_no_char
// rsp     | out       | rsp_valid/rsp_ready  | rsp_out_char, rsp_end_of_run
//
// an input beat is expanded into 0 to 6 characters held in a shift register
// each character leaves in its own rsp beat
// the next input beat is taken in the cycle the last character of the current one leaves
// a beat that expands to nothing is taken without a result
// reset (synchronous) clears the character count; rsp stalls hold the current character
module string_literal_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_is_first,
   input  logic       req_is_last,
   input  logic       req_no_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_end_of_run
);

   sle_pkg::sle_expand_type expand;

   logic [sle_pkg::SeqDepth-1:0][7:0] seq_ff, seq_in;
   logic [2:0]                        rem_ff, rem_in;
   logic                              last_beat;
   logic                              req_fire;
   logic                              rsp_fire;

   sle_expand u_expand (
      .ch       (req_ch),
      .is_first (req_is_first),
      .is_last  (req_is_last),
      .no_char  (req_no_char),
      .expand   (expand)
   );

   assign rsp_valid      = (rem_ff != 3'd0);
   assign rsp_out_char   = seq_ff[0];
   assign last_beat      = (rem_ff == 3'd1);
   assign rsp_end_of_run = last_beat;
   assign rsp_fire       = rsp_valid && rsp_ready;
   assign req_ready      = (rem_ff == 3'd0) || (rsp_ready && last_beat);
   assign req_fire       = req_valid && req_ready;

   always_comb begin
      seq_in = seq_ff;
      rem_in = rem_ff;
      if (req_fire) begin
         seq_in = expand.seq;
         rem_in = expand.count;
      end else if (rsp_fire) begin
         seq_in = {8'h00, seq_ff[sle_pkg::SeqDepth-1:1]};
         rem_in = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      if (reset) begin
         rem_ff <= 3'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

endmodule

/* sv/sle_checker.sv */
`include "string_literal_escaper_assert.svh"

module sle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_end_of_run
);

   // a stalled result beat stays offered
   `SLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // and keeps its character
   `SLE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_char))
   // nothing is offered right after reset
   `SLE_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // no input beat taken while a run is still in the middle
   `SLE_ASSERT_ALWAYS(a_busy_run, clock, reset,
      !(req_valid && req_ready && rsp_valid && !rsp_end_of_run))
   // escaped output is always printable
   `SLE_ASSERT_ALWAYS(a_printable, clock, reset,
      !rsp_valid || (rsp_out_char >= 8'd32 && rsp_out_char <= 8'd126))

endmodule

bind string_literal_escaper sle_checker u_sle_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_char   (rsp_out_char),
   .rsp_end_of_run (rsp_end_of_run)
);
